// ----- rtl/core/ibds_pkg.sv -----
// Shared types and constants for the two-wire bus SCL divider search block.
// Used by the controller, the datapath and the top level.
// No dependencies.
package ibds_pkg;

    localparam int CLK_W  = 32;
    localparam int RATE_W = 22;
    localparam int DIVV_W = 16;
    localparam int TIME_W = 7;

    localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 32'd12000000;

    // Commands from the controller to the datapath; at most one is active per cycle.
    typedef struct packed {
        logic load_item;
        logic calc_prod;
        logic div_start;
        logic take_div;
        logic calc_err;
        logic eval;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic div_done;
        logic stop;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/core/i2c_baud_divider_search_core.sv -----
// Top level of the SCL divider search for a two-wire bus controller.
// Instantiates ibds_ctrl and ibds_datapath; uses ibds_pkg.
//
// Usage: write the input clock in hertz through i_cfg_wen/i_cfg_wdata while
// the block is idle (reset value 12000000). Each beat on the slave stream
// carries a wanted bit rate; the block answers with exactly one beat on the
// master stream holding the divider minus one and the packed SCL timing,
// with too_fast in tuser when even the shortest half period gives divider 0.
// Each tried half-period count steps through the product, the divider start,
// the shared bit-serial 32-bit divider, the error and the evaluation; between
// 1 and MAX_HALF_PERIOD-1 counts are tried for each rate.
// A new beat is taken once the previous result is in the output register.
// One rate is worked on at a time.
// Reset is synchronous and active low; it returns the controller to idle,
// drops the output valid and restores the clock register.
// A stalled receiver holds the result in the output register; the next rate
// may be accepted meanwhile, and its search waits at the end until that
// register frees.
module i2c_baud_divider_search_core #(
    parameter int DIVIDER_LIMIT   = 65536,
    parameter int MAX_HALF_PERIOD = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wen,
    input  logic [ibds_pkg::CLK_W-1:0] i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,  // [21:0] baud_rate, [23:22] zero
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [15:0] divider_value, [22:16] timing_value, [23] zero
    output logic [23:0]                m_axis_tdata,
    output logic                       m_axis_tuser   // [0] too_fast
);
    import ibds_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [DIVV_W-1:0] w_divider_value;
    logic [TIME_W-1:0] w_timing_value;

    ibds_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_cmd     (w_cmd),
        .i_stat    (w_stat)
    );

    ibds_datapath #(
        .DIVIDER_LIMIT   (DIVIDER_LIMIT),
        .MAX_HALF_PERIOD (MAX_HALF_PERIOD)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rate          (s_axis_tdata[RATE_W-1:0]),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_m_ready       (m_axis_tready),
        .o_m_valid       (m_axis_tvalid),
        .o_divider_value (w_divider_value),
        .o_timing_value  (w_timing_value),
        .o_too_fast      (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_timing_value, w_divider_value};

endmodule

// ----- rtl/core/ibds_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Used by the datapath of the SCL divider search; no package dependencies.
module ibds_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int SW = $clog2(DVD_W);
    localparam logic [SW-1:0] LAST_STEP = SW'(DVD_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [SW-1:0]    r_step, n_step;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // The quotient register starts with the dividend; its bits shift out at
    // the top while quotient bits shift in at the bottom.
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo  = {r_quo[DVD_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            n_step = r_step + SW'(1);
            if (r_step == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/ibds_datapath.sv -----
// Datapath of the SCL divider search: clock register, per-count arithmetic,
// best-candidate registers and the result register. Uses ibds_pkg and ibds_div.
module ibds_datapath #(
    parameter int DIVIDER_LIMIT   = 65536,
    parameter int MAX_HALF_PERIOD = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [ibds_pkg::CLK_W-1:0]    i_cfg_wdata,
    input  logic [ibds_pkg::RATE_W-1:0]   i_rate,
    input  ibds_pkg::t_dp_cmd             i_cmd,
    output ibds_pkg::t_dp_stat            o_stat,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [ibds_pkg::DIVV_W-1:0]   o_divider_value,
    output logic [ibds_pkg::TIME_W-1:0]   o_timing_value,
    output logic                          o_too_fast
);
    import ibds_pkg::*;

    localparam int CW = $clog2(MAX_HALF_PERIOD + 1);
    localparam int PW = RATE_W + $clog2(2 * MAX_HALF_PERIOD + 1);
    localparam int DW = $clog2(DIVIDER_LIMIT + 1);
    localparam int MW = PW + DW;

    localparam logic [CW-1:0]    CNT_MAX = CW'(MAX_HALF_PERIOD);
    localparam logic [CW-1:0]    CNT_MIN = CW'(2);
    localparam logic [DW-1:0]    LIM_D   = DW'(DIVIDER_LIMIT);
    localparam logic [CLK_W-1:0] LIM_Q   = CLK_W'(DIVIDER_LIMIT);

    logic [CLK_W-1:0]  r_clock_hz;
    logic [RATE_W-1:0] r_rate;
    logic [CW-1:0]     r_cnt;
    logic [PW-1:0]     r_prod;
    logic [DW-1:0]     r_div;
    logic [CLK_W-1:0]  r_err;
    logic              r_have;
    logic [DW-1:0]     r_pick_div;
    logic [CW-1:0]     r_pick_cnt;
    logic [CLK_W-1:0]  r_pick_err;
    logic              r_out_valid;
    logic [DIVV_W-1:0] r_divider_value;
    logic [TIME_W-1:0] r_timing_value;
    logic              r_too_fast;

    logic              w_div_done;
    logic [CLK_W-1:0]  w_quo;
    logic [MW-1:0]     w_pd;
    logic              w_stop;
    logic              w_better;
    logic              w_fast;
    logic [2:0]        w_t;

    ibds_div #(
        .DVD_W (CLK_W),
        .DVS_W (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_clock_hz),
        .i_divisor  (r_prod),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // The divider never exceeds clock/prod, so prod*div fits in the clock width.
    assign w_pd     = MW'(r_prod) * MW'(r_div);
    assign w_stop   = (r_err == '0) || (r_div >= LIM_D) || (r_cnt == CNT_MIN);
    assign w_better = !r_have || (r_err < r_pick_err);
    assign w_fast   = (r_pick_div == '0);
    assign w_t      = 3'(r_pick_cnt - CNT_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz  <= CLOCK_HZ_RESET;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_clock_hz <= i_cfg_wdata;
            end
            if (i_cmd.load_item) begin
                r_have <= 1'b0;
            end else if (i_cmd.eval) begin
                r_have <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_rate <= i_rate;
            r_cnt  <= CNT_MAX;
        end
        if (i_cmd.calc_prod) begin
            r_prod <= PW'(r_rate) * PW'({r_cnt, 1'b0});
        end
        if (i_cmd.take_div) begin
            // A zero divisor yields an all-ones quotient, which clamps as well.
            r_div <= (r_prod == '0 || w_quo > LIM_Q) ? LIM_D : DW'(w_quo);
        end
        if (i_cmd.calc_err) begin
            r_err <= r_clock_hz - CLK_W'(w_pd);
        end
        if (i_cmd.eval) begin
            if (w_better) begin
                r_pick_div <= r_div;
                r_pick_cnt <= r_cnt;
                r_pick_err <= r_err;
            end
            if (!w_stop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_divider_value <= w_fast ? '0 : DIVV_W'(r_pick_div - DW'(1));
            r_timing_value  <= {w_t, 1'b0, w_t};
            r_too_fast      <= w_fast;
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.stop     = w_stop;
    assign o_stat.out_free = !r_out_valid || i_m_ready;

    assign o_m_valid       = r_out_valid;
    assign o_divider_value = r_divider_value;
    assign o_timing_value  = r_timing_value;
    assign o_too_fast      = r_too_fast;

`ifndef SYNTH
    a_last_count_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_cnt == CNT_MIN) |-> w_stop)
        else $error("search did not stop at the smallest count");

    a_zero_prod_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_div && r_prod == '0) |=> (r_div == LIM_D))
        else $error("zero product did not clamp the divider");

    a_div_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (r_div <= LIM_D))
        else $error("divider above limit at evaluation");
`endif

endmodule

// ----- rtl/core/ibds_ctrl.sv -----
// Controller state machine of the SCL divider search.
// Sequences the datapath through each half-period count; uses ibds_pkg.
module ibds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    output ibds_pkg::t_dp_cmd  o_cmd,
    input  ibds_pkg::t_dp_stat i_stat
);
    import ibds_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROD  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.calc_prod = 1'b1;
                n_state         = S_START;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.take_div = 1'b1;
                    n_state        = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.stop ? S_DONE : S_PROD;
            end
            S_DONE: begin
                // Wait here only while an older result is still held downstream.
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_load_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> $past(i_stat.stop))
        else $error("result loaded before the search stopped");
`endif

endmodule
